@@ rtl/drc_pkg.sv @@
// ----------------------------------------------------------------------------
// drc_pkg: shared types and constants for the DMA ring consumer tracker
// Widths, operation codes, sequencer states and the register reset value.
// ----------------------------------------------------------------------------
package drc_pkg;

    localparam int IDX_W  = 16;   // ring index width, 8..16
    localparam int CUR_W  = 32;   // cursor and counter width
    localparam int FLD_W  = 16;   // fixed 16-bit fields on the ports
    localparam int LOST_W = 16;   // lost count is kept modulo 2^16

    localparam int MUL_CNT_W = $clog2(IDX_W);
    localparam int DIV_STEPS = CUR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [FLD_W-1:0] RING_SIZE_RESET = FLD_W'(256);

    typedef enum logic [1:0] {
        OP_POLL    = 2'd0,
        OP_LAP     = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CAND,
        S_OVR,
        S_MOD,
        S_PEND,
        S_FORM,
        S_RESTART,
        S_OUT1,
        S_OUT2
    } state_t;

endpackage

@@ rtl/drc_ifs.sv @@
// ----------------------------------------------------------------------------
// drc_ifs: request and segment channel interfaces
// Valid/ready channels carrying one request or one result segment.
// ----------------------------------------------------------------------------
interface drc_cmd_if
    import drc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [CUR_W-1:0]   laps;
    logic [FLD_W-1:0]   remaining_count;

    modport source (output valid, output operation, output laps,
                    output remaining_count, input ready);
    modport sink   (input valid, input operation, input laps,
                    input remaining_count, output ready);
endinterface

interface drc_seg_if
    import drc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               status;
    logic [FLD_W-1:0]   segment_start;
    logic [FLD_W-1:0]   segment_length;
    logic [LOST_W-1:0]  lost_bytes;
    logic [CUR_W-1:0]   overrun_total;
    logic               last;

    modport source (output valid, output status, output segment_start,
                    output segment_length, output lost_bytes,
                    output overrun_total, output last, input ready);
    modport sink   (input valid, input status, input segment_start,
                    input segment_length, input lost_bytes,
                    input overrun_total, input last, output ready);
endinterface

@@ rtl/drc_mul.sv @@
// ----------------------------------------------------------------------------
// drc_mul: bit-serial multiplier, cursor by ring size modulo 2^32
// Shift-and-add over the IDX_W ring size bits, one bit per cycle.
// ----------------------------------------------------------------------------
module drc_mul
    import drc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [CUR_W-1:0]   a,
    input  logic [IDX_W-1:0]   b,
    output logic               done,
    output logic [CUR_W-1:0]   product
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CUR_W-1:0]     a_reg, a_next;
    logic [IDX_W-1:0]     b_reg, b_next;
    logic [CUR_W-1:0]     acc_reg, acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplicand when the current bit is set
            if (b_reg[0])
                acc_next = acc_reg + a_reg;
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(IDX_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/drc_mod.sv @@
// ----------------------------------------------------------------------------
// drc_mod: bit-serial remainder of a cursor by the ring size
// Restoring division over the CUR_W dividend bits, one bit per cycle.
// ----------------------------------------------------------------------------
module drc_mod
    import drc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [CUR_W-1:0]   dividend,
    input  logic [IDX_W-1:0]   divisor,
    output logic               done,
    output logic [IDX_W-1:0]   remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CUR_W-1:0]     dvd_reg, dvd_next;
    logic [IDX_W-1:0]     div_reg, div_next;
    logic [IDX_W-1:0]     rem_reg, rem_next;
    logic [IDX_W:0]       trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[CUR_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit and subtract when it fits
            if (trial >= {1'b0, div_reg})
                rem_next = IDX_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[IDX_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/dma_ring_consumer_tracker.sv @@
// ----------------------------------------------------------------------------
// dma_ring_consumer_tracker: consumer side of a DMA-filled receive ring
// Rebuilds the producer cursor, drops overwritten bytes and reports segments.
// ----------------------------------------------------------------------------
// Restart and error-free poll requests use the serial multiplier, and a poll
// with an overrun also the serial remainder; a split poll gives its second
// segment after the first, when the sink is ready. Throughput: one request
// at a time, taken again once the last result is in the output register.
// Reset clears all cursors and counters, ring size 256.
module dma_ring_consumer_tracker
    import drc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [FLD_W-1:0]   cfg_wr_data,
    drc_cmd_if.sink            cmd,
    drc_seg_if.source          seg
);

    // ring size register, taken in its low IDX_W bits
    logic [IDX_W-1:0] size_reg;

    // sequencer and tracker state
    state_t           state_reg, state_next;
    logic [CUR_W-1:0] prod_reg, prod_next;
    logic [CUR_W-1:0] cons_reg, cons_next;
    logic [CUR_W-1:0] ovr_reg, ovr_next;
    logic [CUR_W-1:0] lap_reg, lap_next;
    logic [IDX_W-1:0] rp_reg, rp_next;

    // per-request working values
    logic [IDX_W-1:0]  widx_reg, widx_next;
    logic [CUR_W-1:0]  cand_reg, cand_next;
    logic [CUR_W-1:0]  pend_reg, pend_next;
    logic [LOST_W-1:0] lost_reg, lost_next;

    // staged result, second segment length for a split poll
    logic              res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_start_reg, res_start_next;
    logic [IDX_W-1:0]  res_len_reg, res_len_next;
    logic              res_last_reg, res_last_next;
    logic [IDX_W-1:0]  res2_len_reg, res2_len_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              out_status_reg, out_status_next;
    logic [FLD_W-1:0]  out_start_reg, out_start_next;
    logic [FLD_W-1:0]  out_len_reg, out_len_next;
    logic [LOST_W-1:0] out_lost_reg, out_lost_next;
    logic [CUR_W-1:0]  out_ovr_reg, out_ovr_next;
    logic              out_last_reg, out_last_next;

    // serial units
    logic             mul_start, mul_done;
    logic [CUR_W-1:0] mul_a, mul_product;
    logic             mod_start, mod_done;
    logic [IDX_W-1:0] mod_rem;

    // combinational helpers
    logic             accept;
    logic             out_free;
    op_t              op;
    logic             poll_err;
    logic [CUR_W-1:0] pend_now;
    logic [CUR_W-1:0] excess;
    logic [IDX_W-1:0] span;
    logic [IDX_W:0]   end_pos;
    logic [IDX_W-1:0] first_len;

    drc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (size_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    drc_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (prod_reg),
        .divisor   (size_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign op        = op_t'(cmd.operation);
    assign out_free  = !out_valid_reg || seg.ready;

    // error when the ring is empty-sized or the sample exceeds the ring
    assign poll_err  = (size_reg == '0) ||
                       (cmd.remaining_count > FLD_W'(size_reg));

    // restart multiplies the lap counter, poll the sampled lap count
    assign mul_a     = (op == OP_RESTART) ? lap_reg : cmd.laps;
    assign mul_start = accept &&
                       ((op == OP_RESTART) || ((op == OP_POLL) && !poll_err));

    assign pend_now  = prod_reg - cons_reg;
    assign excess    = pend_now - CUR_W'(size_reg);
    assign span      = (pend_reg > CUR_W'(size_reg)) ? size_reg
                                                     : pend_reg[IDX_W-1:0];
    assign end_pos   = {1'b0, rp_reg} + {1'b0, span};
    assign first_len = size_reg - rp_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= RING_SIZE_RESET[IDX_W-1:0];
        else if (cfg_wr_en)
            size_reg <= cfg_wr_data[IDX_W-1:0];
    end

    // control and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prod_reg      <= '0;
            cons_reg      <= '0;
            ovr_reg       <= '0;
            lap_reg       <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prod_reg      <= prod_next;
            cons_reg      <= cons_next;
            ovr_reg       <= ovr_next;
            lap_reg       <= lap_next;
            rp_reg        <= rp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        widx_reg       <= widx_next;
        cand_reg       <= cand_next;
        pend_reg       <= pend_next;
        lost_reg       <= lost_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_len_reg    <= res_len_next;
        res_last_reg   <= res_last_next;
        res2_len_reg   <= res2_len_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_len_reg    <= out_len_next;
        out_lost_reg   <= out_lost_next;
        out_ovr_reg    <= out_ovr_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        prod_next       = prod_reg;
        cons_next       = cons_reg;
        ovr_next        = ovr_reg;
        lap_next        = lap_reg;
        rp_next         = rp_reg;
        widx_next       = widx_reg;
        cand_next       = cand_reg;
        pend_next       = pend_reg;
        lost_next       = lost_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_len_next    = res_len_reg;
        res_last_next   = res_last_reg;
        res2_len_next   = res2_len_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_len_next    = out_len_reg;
        out_lost_next   = out_lost_reg;
        out_ovr_next    = out_ovr_reg;
        out_last_next   = out_last_reg;
        mod_start       = 1'b0;

        // drop the output once the sink has taken it
        if (out_valid_reg && seg.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // default result: ok, zero length, current read index
                    res_status_next = 1'b0;
                    res_start_next  = rp_reg;
                    res_len_next    = '0;
                    res_last_next   = 1'b1;
                    lost_next       = '0;
                    unique case (op)
                        OP_POLL:
                        begin
                            if (poll_err)
                            begin
                                // error leaves all state alone
                                res_status_next = 1'b1;
                                res_start_next  = '0;
                                state_next      = S_OUT1;
                            end
                            else
                            begin
                                // a zero sample means the ring is full to its end
                                if (cmd.remaining_count == '0)
                                    widx_next = size_reg;
                                else
                                    widx_next = size_reg -
                                                cmd.remaining_count[IDX_W-1:0];
                                state_next = S_MUL;
                            end
                        end
                        OP_LAP:
                        begin
                            lap_next   = lap_reg + CUR_W'(1);
                            state_next = S_OUT1;
                        end
                        OP_RESTART:
                        begin
                            state_next = S_RESTART;
                        end
                        OP_NONE:
                        begin
                            state_next = S_OUT1;
                        end
                        default:
                        begin
                            state_next = S_OUT1;
                        end
                    endcase
                end
            end

            S_MUL:
            begin
                // candidate producer cursor from laps * size + write index
                if (mul_done)
                begin
                    cand_next  = mul_product + CUR_W'(widx_reg);
                    state_next = S_CAND;
                end
            end

            S_CAND:
            begin
                // advance the producer cursor only forward
                if (cand_reg > prod_reg)
                    prod_next = cand_reg;
                state_next = S_OVR;
            end

            S_OVR:
            begin
                if (pend_now > CUR_W'(size_reg))
                begin
                    // overrun: skip the overwritten prefix, then re-derive index
                    lost_next  = excess[LOST_W-1:0];
                    ovr_next   = ovr_reg + CUR_W'(excess[LOST_W-1:0]);
                    cons_next  = cons_reg + CUR_W'(excess[LOST_W-1:0]);
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_PEND;
                end
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    rp_next    = mod_rem;
                    state_next = S_PEND;
                end
            end

            S_PEND:
            begin
                pend_next = pend_now;
                // a stale index past a shrunk ring restarts at zero
                if (rp_reg >= size_reg)
                    rp_next = '0;
                state_next = S_FORM;
            end

            S_FORM:
            begin
                res_start_next = rp_reg;
                res_last_next  = 1'b1;
                if (pend_reg == '0)
                begin
                    res_len_next = '0;
                end
                else
                begin
                    cons_next = cons_reg + CUR_W'(span);
                    if (end_pos <= {1'b0, size_reg})
                    begin
                        // one segment, wrap the index exactly at the ring end
                        res_len_next = span;
                        if (end_pos == {1'b0, size_reg})
                            rp_next = '0;
                        else
                            rp_next = end_pos[IDX_W-1:0];
                    end
                    else
                    begin
                        // split at the ring end
                        res_len_next  = first_len;
                        res2_len_next = span - first_len;
                        res_last_next = 1'b0;
                        rp_next       = span - first_len;
                    end
                end
                state_next = S_OUT1;
            end

            S_RESTART:
            begin
                // rebaseline both cursors at the lap boundary
                if (mul_done)
                begin
                    prod_next      = mul_product;
                    cons_next      = mul_product;
                    rp_next        = '0;
                    res_start_next = '0;
                    state_next     = S_OUT1;
                end
            end

            S_OUT1:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = FLD_W'(res_start_reg);
                    out_len_next    = FLD_W'(res_len_reg);
                    out_lost_next   = lost_reg;
                    out_ovr_next    = ovr_reg;
                    out_last_next   = res_last_reg;
                    state_next      = res_last_reg ? S_IDLE : S_OUT2;
                end
            end

            S_OUT2:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = 1'b0;
                    out_start_next  = '0;
                    out_len_next    = FLD_W'(res2_len_reg);
                    out_lost_next   = lost_reg;
                    out_ovr_next    = ovr_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign seg.valid          = out_valid_reg;
    assign seg.status         = out_status_reg;
    assign seg.segment_start  = out_start_reg;
    assign seg.segment_length = out_len_reg;
    assign seg.lost_bytes     = out_lost_reg;
    assign seg.overrun_total  = out_ovr_reg;
    assign seg.last           = out_last_reg;

endmodule

@@ tb/drc_segment_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_segment_checker: ring tracker predictor and segment scoreboard
// Watches the request, segment and register channels, works out the segments
// each request must give and compares every delivered segment field by field.
// ----------------------------------------------------------------------------
module drc_segment_checker
    import drc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [FLD_W-1:0]   cfg_wr_data,
    drc_cmd_if                 cmd,
    drc_seg_if                 seg,
    output int                 mismatches,
    output int                 open_results,
    output int                 segments_checked,
    output int                 split_polls,
    output int                 overrun_polls,
    output int                 error_polls
);

    typedef struct packed {
        logic               status;
        logic [FLD_W-1:0]   start;
        logic [FLD_W-1:0]   length;
        logic [LOST_W-1:0]  lost;
        logic [CUR_W-1:0]   total;
        logic               last;
    } segment_t;

    segment_t          expected_segments[$];
    segment_t          seen;

    // tracker state as the block should hold it
    logic [FLD_W-1:0]  ring_len;
    logic [CUR_W-1:0]  producer;
    logic [CUR_W-1:0]  consumer;
    logic [CUR_W-1:0]  overrun;
    logic [CUR_W-1:0]  laps_taken;
    logic [FLD_W-1:0]  read_pos;

    int n_bad, n_checked, n_split, n_ovr, n_err;

    function automatic segment_t make_segment(logic status, logic [FLD_W-1:0] start,
                                              logic [FLD_W-1:0] length,
                                              logic [LOST_W-1:0] lost, logic last);
        segment_t s;
        s.status = status;
        s.start  = start;
        s.length = length;
        s.lost   = lost;
        s.total  = overrun;
        s.last   = last;
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: segment mismatch on %s: got %0h, want %0h", $time, what, got, want);
        n_bad++;
    endtask

    task automatic predict_segments(op_t op, logic [CUR_W-1:0] laps_in,
                                    logic [FLD_W-1:0] remaining);
        logic [CUR_W-1:0] len_w, write_idx, candidate, pending, lost, span, pos, head;
        len_w = CUR_W'(ring_len);
        lost  = '0;
        if (op != OP_POLL) begin
            if (op == OP_LAP)
                laps_taken = laps_taken + 1;
            else if (op == OP_RESTART) begin
                producer = laps_taken * len_w;
                consumer = producer;
                read_pos = '0;
            end
            expected_segments.push_back(make_segment(1'b0, read_pos, '0, '0, 1'b1));
            return;
        end
        // bad size or impossible sample: flag it and leave the state alone
        if (len_w == 0 || CUR_W'(remaining) > len_w) begin
            n_err++;
            expected_segments.push_back(make_segment(1'b1, '0, '0, '0, 1'b1));
            return;
        end
        write_idx = (remaining == 0) ? len_w : len_w - CUR_W'(remaining);
        candidate = laps_in * len_w + write_idx;
        if (candidate > producer)
            producer = candidate;
        pending = producer - consumer;
        pos     = CUR_W'(read_pos);
        if (pending > len_w) begin
            n_ovr++;
            lost     = (pending - len_w) & 32'h0000_FFFF;
            overrun  = overrun + lost;
            consumer = consumer + lost;
            pos      = producer % len_w;
            pending  = producer - consumer;
        end
        if (pos >= len_w)
            pos = '0;
        if (pending == 0) begin
            expected_segments.push_back(make_segment(1'b0, pos[FLD_W-1:0], '0,
                                                     lost[LOST_W-1:0], 1'b1));
            read_pos = pos[FLD_W-1:0];
            return;
        end
        span     = (pending > len_w) ? len_w : pending;
        consumer = consumer + span;
        if (pos + span <= len_w) begin
            expected_segments.push_back(make_segment(1'b0, pos[FLD_W-1:0], span[FLD_W-1:0],
                                                     lost[LOST_W-1:0], 1'b1));
            pos = (pos + span == len_w) ? '0 : pos + span;
        end else begin
            // wraps past the ring end: tail first, then the head from index zero
            n_split++;
            head = len_w - pos;
            expected_segments.push_back(make_segment(1'b0, pos[FLD_W-1:0], head[FLD_W-1:0],
                                                     lost[LOST_W-1:0], 1'b0));
            expected_segments.push_back(make_segment(1'b0, '0, FLD_W'(span - head),
                                                     lost[LOST_W-1:0], 1'b1));
            pos = span - head;
        end
        read_pos = pos[FLD_W-1:0];
    endtask

    task automatic compare_segment(segment_t got);
        segment_t want;
        if (expected_segments.size() == 0) begin
            report_mismatch("segment start with nothing expected", 32'(got.start), '0);
            return;
        end
        want = expected_segments.pop_front();
        n_checked++;
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.start  !== want.start)
            report_mismatch("segment_start", 32'(got.start), 32'(want.start));
        if (got.length !== want.length)
            report_mismatch("segment_length", 32'(got.length), 32'(want.length));
        if (got.lost   !== want.lost)
            report_mismatch("lost_bytes", 32'(got.lost), 32'(want.lost));
        if (got.total  !== want.total)
            report_mismatch("overrun_total", got.total, want.total);
        if (got.last   !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_segments.delete();
            ring_len   = RING_SIZE_RESET;
            producer   = '0;
            consumer   = '0;
            overrun    = '0;
            laps_taken = '0;
            read_pos   = '0;
        end
        else
        begin
            // retire the delivered segment before taking a new request
            if (seg.valid && seg.ready)
            begin
                seen = '{seg.status, seg.segment_start, seg.segment_length,
                         seg.lost_bytes, seg.overrun_total, seg.last};
                compare_segment(seen);
            end
            if (cfg_wr_en)
                ring_len = cfg_wr_data;
            if (cmd.valid && cmd.ready)
                predict_segments(op_t'(cmd.operation), cmd.laps, cmd.remaining_count);
        end
        mismatches       <= n_bad;
        open_results     <= expected_segments.size();
        segments_checked <= n_checked;
        split_polls      <= n_split;
        overrun_polls    <= n_ovr;
        error_polls      <= n_err;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the DMA ring consumer tracker
// Drives directed and random poll, lap, restart and unused-code requests over several ring
// sizes with bursty requests and a stalling segment receiver; the checker
// beside the block predicts and compares every segment.
// ----------------------------------------------------------------------------
module testbench;
    import drc_pkg::*;

    localparam int ITEMS_PER_PHASE = 72;
    localparam int STALL_LIMIT     = 3000;  // cycles with no handshake at all
    localparam int LONG_HOLD       = 400;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES    = 60;    // covers the slowest overrun poll

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [FLD_W-1:0]   cfg_wr_data;

    drc_cmd_if cmd_ch ();
    drc_seg_if seg_ch ();

    int mismatches, open_results, segments_checked;
    int split_polls, overrun_polls, error_polls;

    // sender side bookkeeping
    int                 burst_left    = 0;
    int                 requests_sent = 0;
    int                 sizes_used    = 0;
    int                 ring_now      = 256;
    logic [CUR_W-1:0]   laps_noted    = '0;   // lap requests accepted so far
    logic [CUR_W-1:0]   dma_lap       = '0;   // modeled DMA position: lap ...
    int                 dma_idx       = 0;    // ... and write index in the ring
    int                 hold_asked    = 0;

    // receiver side bookkeeping
    int hold_seen  = 0;
    int hold_left  = 0;
    int mode_left  = 0;
    int stall_mode = 0;

    int quiet_cycles = 0;

    logic [FLD_W-1:0] phase_sizes [8] = '{16'd256, 16'd1, 16'd65535, 16'd2,
                                          16'd100, 16'd4096, 16'd0, 16'd40};

    dma_ring_consumer_tracker u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_ch),
        .seg         (seg_ch)
    );

    drc_segment_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .cmd              (cmd_ch),
        .seg              (seg_ch),
        .mismatches       (mismatches),
        .open_results     (open_results),
        .segments_checked (segments_checked),
        .split_polls      (split_polls),
        .overrun_polls    (overrun_polls),
        .error_polls      (error_polls)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Segment receiver: switch between stall patterns every so often, and
    // hold ready low for a long stretch whenever the stimulus asks for it.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            seg_ch.ready <= 1'b0;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
            seg_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 160);
            end
            mode_left--;
            case (stall_mode)
                0:       seg_ch.ready <= 1'b1;                       // no stalls
                1:       seg_ch.ready <= 1'($urandom_range(0, 1));   // coin flip
                2:       seg_ch.ready <= ($urandom_range(0, 7) != 0);
                default: seg_ch.ready <= ~seg_ch.ready;              // alternating
            endcase
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (seg_ch.valid && seg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one request and hold it until accepted. Between bursts, drop
    // valid for a random gap; a zero gap keeps the stream back to back.
    task automatic send_request(op_t op, logic [CUR_W-1:0] laps,
                                logic [FLD_W-1:0] remaining);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        cmd_ch.valid           <= 1'b1;
        cmd_ch.operation       <= op;
        cmd_ch.laps            <= laps;
        cmd_ch.remaining_count <= remaining;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        burst_left--;
        requests_sent++;
        if (op == OP_LAP)
            laps_noted++;
    endtask

    // Stop offering and wait until every predicted segment has come back.
    // Skip one edge first so the checker's count includes the last request.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_ring_size(logic [FLD_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ring_now = int'(value);
        sizes_used++;
    endtask

    // Rebaseline the block and bring the modeled DMA back to the lap boundary.
    task automatic restart_ring();
        send_request(OP_RESTART, $urandom, FLD_W'($urandom));
        dma_lap = laps_noted;
        dma_idx = 0;
    endtask

    // Well-formed traffic: move the DMA forward, note every lap it completes,
    // then poll with the matching lap count and remaining-count sample.
    // Mostly at most a ring's worth, now and then enough to overrun; a zero ring only polls.
    task automatic advance_dma();
        int step;
        if (ring_now == 0)
        begin
            send_request(OP_POLL, $urandom, FLD_W'($urandom_range(0, 3)));
            return;
        end
        step = ($urandom_range(0, 9) == 0) ? ring_now + $urandom_range(1, 2 * ring_now)
                                           : $urandom_range(0, ring_now);
        dma_idx += step;
        while (dma_idx >= ring_now)
        begin
            dma_idx -= ring_now;
            dma_lap++;
            send_request(OP_LAP, $urandom, FLD_W'($urandom));
        end
        // at a lap boundary, sometimes report it as a full ring of the lap before
        if (dma_idx == 0 && dma_lap != 0 && $urandom_range(0, 1) == 1)
            send_request(OP_POLL, dma_lap - 1, FLD_W'(0));
        else
            send_request(OP_POLL, dma_lap, FLD_W'(ring_now - dma_idx));
    endtask

    // Noise: any operation, laps near the DMA or anywhere, any sample.
    task automatic noise_request();
        op_t              op;
        logic [CUR_W-1:0] laps;
        logic [FLD_W-1:0] remaining;
        op        = op_t'($urandom_range(0, 3));
        laps      = ($urandom_range(0, 3) == 0) ? $urandom : dma_lap + $urandom_range(0, 2);
        remaining = ($urandom_range(0, 1) == 0) ? FLD_W'($urandom_range(0, 65535))
                                                : FLD_W'($urandom_range(0, ring_now));
        send_request(op, laps, remaining);
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 72)
            advance_dma();
        else if (pick < 78)
            restart_ring();
        else
            noise_request();
    endtask

    initial
    begin
        int  phase_end;
        int  phase_start;
        bit  hold_done;
        bit  pause_done;

        hold_done  = 1'b0;
        pause_done = 1'b0;
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        cmd_ch.valid           = 1'b0;
        cmd_ch.operation       = OP_POLL;
        cmd_ch.laps            = '0;
        cmd_ch.remaining_count = '0;
        seg_ch.ready           = 1'b0;
        phase_sizes[6] = FLD_W'($urandom_range(5, 65535));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, ring size 256 from reset ----
        send_request(OP_POLL, 32'd0, 16'd256);       // write index zero: nothing pending
        send_request(OP_POLL, 32'd0, 16'd100);       // one segment from the start
        send_request(OP_POLL, 32'd0, 16'd0);         // ring full: segment ends at ring end
        send_request(OP_LAP, 32'd0, 16'd0);
        send_request(OP_POLL, 32'd1, 16'd200);
        send_request(OP_POLL, 32'd2, 16'd50);        // overrun, then split at the ring end
        send_request(OP_POLL, 32'd0, 16'd300);       // sample beyond the ring size
        send_request(OP_POLL, 32'd0, 16'd10);        // older cursor: producer holds
        send_request(OP_RESTART, 32'd0, 16'd0);
        send_request(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_POLL, 32'd1, 16'd56);        // leaves the read index at 200

        // shrink the ring below the read index: stale position without overrun
        write_ring_size(16'd16);
        send_request(OP_POLL, 32'd28, 16'd3);
        send_request(OP_POLL, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_POLL, 32'hFFFF_FFFF, 16'd1);  // cursor wraps, huge overrun

        // zero size: every poll is an error
        write_ring_size(16'd0);
        send_request(OP_POLL, 32'd5, 16'd0);
        send_request(OP_LAP, 32'd0, 16'd0);
        send_request(OP_RESTART, 32'd0, 16'd0);

        write_ring_size(16'hFFFF);
        send_request(OP_POLL, 32'd0, 16'hFFFF);
        send_request(OP_POLL, 32'd0, 16'd0);          // a full ring of the largest size
        send_request(OP_POLL, 32'h8000_0000, 16'h8000);
        send_request(OP_RESTART, 32'd0, 16'd0);

        write_ring_size(16'd1);
        send_request(OP_POLL, 32'd200000, 16'd1);
        send_request(OP_POLL, 32'd200000, 16'd0);

        // ---- random phases, one ring size each ----
        // Even phases start from a restart; odd ones keep the old cursors so
        // the size change itself leaves stale positions and big overruns.
        for (int p = 0; p < 8; p++)
        begin
            write_ring_size(phase_sizes[p]);
            if (p % 2 == 0)
                restart_ring();
            phase_start = requests_sent;
            phase_end   = requests_sent + ITEMS_PER_PHASE;
            while (requests_sent < phase_end)
            begin
                // hold the receiver off while requests keep coming: fill the block
                if (p == 2 && !hold_done && requests_sent >= phase_start + 20)
                begin
                    hold_asked <= hold_asked + 1;
                    hold_done = 1'b1;
                end
                // pause mid-phase until every segment is back
                if (p == 4 && !pause_done && requests_sent >= phase_start + 30)
                begin
                    wait_drained();
                    pause_done = 1'b1;
                end
                random_request();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests over %0d ring size settings, %0d segments checked",
                 requests_sent, sizes_used, segments_checked);
        $display("  including %0d split polls, %0d overrun polls and %0d rejected polls",
                 split_polls, overrun_polls, error_polls);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/drc_pkg.sv
rtl/drc_ifs.sv
rtl/drc_mul.sv
rtl/drc_mod.sv
rtl/dma_ring_consumer_tracker.sv
tb/drc_segment_checker.sv
tb/testbench.sv
